// File: rtl/lcar_pkg.sv
// Package for the load-cell converter reader: tick phases, field widths and
// the command and status records passed between controller and datapath.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package lcar_pkg;

	localparam int DataBits   = 24;
	localparam int MaxSamples = 127;
	localparam int SumBits    = 32;
	localparam int CountBits  = 8;
	localparam int BitCntBits = 5;
	localparam int DivBits    = 32;

	localparam logic [1:0] OpNone    = 2'd0;
	localparam logic [1:0] OpMeasure = 2'd1;
	localparam logic [1:0] OpTare    = 2'd2;

	localparam logic [1:0] RegGainA   = 2'd0;
	localparam logic [1:0] RegScaleA  = 2'd1;
	localparam logic [1:0] RegScaleB  = 2'd2;

	localparam logic signed [31:0] ScaleOne = 32'sd65536;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_WAIT,
		PH_BIT_HI,
		PH_BIT_LO,
		PH_GAIN_HI,
		PH_GAIN_LO,
		PH_DIV,
		PH_MUL,
		PH_OUT
	} phase_t;

	typedef struct packed {
		logic       start;
		logic       clear_word;
		logic       shift_in;
		logic       accumulate;
		logic       div_start;
		logic       div_step;
		logic       mul_start;
		logic       finish;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic mul_done;
	} dp_sts_t;

endpackage
`default_nettype wire

// File: rtl/lcar_stream_if.sv
// Valid/ready channel interface carrying one word per handshake.
// Depends on nothing; payload type is a parameter of the interface.
`timescale 1ns / 1ps
`default_nettype none
interface lcar_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/lcar_ctrl.sv
// Controller sequencing the serial read, gain pulses, division and scaling.
// Depends on lcar_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lcar_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              tick,
	input  wire logic              req,
	input  wire logic              data_level,
	input  wire logic              req_ch,
	input  wire logic [1:0]        gain_a_pulses,
	input  wire logic [7:0]        req_n,
	input  wire lcar_pkg::dp_sts_t sts,
	output lcar_pkg::phase_t       phase,
	output lcar_pkg::dp_cmd_t      cmd,
	output logic                   clock_level,
	output logic                   busy,
	output logic                   arith_busy
);
	lcar_pkg::phase_t phase_q, phase_d;
	logic [lcar_pkg::BitCntBits-1:0] bit_q;
	logic [1:0] pulse_q;
	logic [lcar_pkg::CountBits-1:0] conv_q;
	logic [1:0] pulses;
	logic last_pulse, last_conv, final_lo;

	assign pulses = req_ch ? 2'd2 : (gain_a_pulses == 2'd0 ? 2'd1 : gain_a_pulses);
	assign last_pulse = (pulse_q + 2'd1) >= pulses;
	assign last_conv = (conv_q + 8'd1) > req_n;
	assign phase = phase_q;
	// The low tick of the last gain pulse of the last conversion is held off
	// until the average and weight are ready; it is then taken in PH_OUT.
	assign final_lo = phase_q == lcar_pkg::PH_GAIN_LO && last_pulse && last_conv;
	assign arith_busy = final_lo || phase_q == lcar_pkg::PH_DIV || phase_q == lcar_pkg::PH_MUL;

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			lcar_pkg::PH_IDLE:    if (tick && req) phase_d = lcar_pkg::PH_WAIT;
			lcar_pkg::PH_WAIT:    if (tick && !data_level) phase_d = lcar_pkg::PH_BIT_HI;
			lcar_pkg::PH_BIT_HI:  if (tick) phase_d = lcar_pkg::PH_BIT_LO;
			lcar_pkg::PH_BIT_LO: begin
				if (tick) phase_d = (bit_q == 5'(lcar_pkg::DataBits - 1)) ?
					lcar_pkg::PH_GAIN_HI : lcar_pkg::PH_BIT_HI;
			end
			lcar_pkg::PH_GAIN_HI: if (tick) phase_d = lcar_pkg::PH_GAIN_LO;
			lcar_pkg::PH_GAIN_LO: begin
				if (final_lo) phase_d = lcar_pkg::PH_DIV;
				else if (tick) begin
					if (!last_pulse) phase_d = lcar_pkg::PH_GAIN_HI;
					else phase_d = lcar_pkg::PH_WAIT;
				end
			end
			lcar_pkg::PH_DIV:     if (sts.div_done) phase_d = lcar_pkg::PH_MUL;
			lcar_pkg::PH_MUL:     if (sts.mul_done) phase_d = lcar_pkg::PH_OUT;
			lcar_pkg::PH_OUT:     if (tick) phase_d = lcar_pkg::PH_IDLE;
			default:              phase_d = lcar_pkg::PH_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		clock_level = 1'b0;
		busy = 1'b1;
		case (phase_q)
			lcar_pkg::PH_IDLE: begin
				busy = req;
				cmd.start = tick && req;
			end
			lcar_pkg::PH_WAIT:    cmd.clear_word = tick && !data_level;
			lcar_pkg::PH_BIT_HI:  clock_level = 1'b1;
			lcar_pkg::PH_BIT_LO:  cmd.shift_in = tick;
			lcar_pkg::PH_GAIN_HI: clock_level = 1'b1;
			lcar_pkg::PH_GAIN_LO: begin
				cmd.accumulate = (tick || last_conv) && last_pulse && conv_q != 8'd0;
				cmd.div_start = final_lo;
			end
			lcar_pkg::PH_DIV: begin
				cmd.div_step = 1'b1;
				cmd.mul_start = sts.div_done;
			end
			lcar_pkg::PH_OUT:     cmd.finish = tick;
			default:              busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lcar_pkg::PH_IDLE;
			bit_q   <= '0;
			pulse_q <= '0;
			conv_q  <= '0;
		end else begin
			phase_q <= phase_d;
			if (cmd.start) conv_q <= '0;
			if (cmd.clear_word) bit_q <= '0;
			if (cmd.shift_in) begin
				bit_q <= bit_q + 5'd1;
				pulse_q <= '0;
			end
			if (phase_q == lcar_pkg::PH_GAIN_LO && tick) begin
				pulse_q <= pulse_q + 2'd1;
				if (last_pulse) conv_q <= conv_q + 8'd1;
			end
		end
	end

	property p_clock_low_idle;
		@(posedge clk) disable iff (!arst_n) phase_q == lcar_pkg::PH_IDLE |-> !clock_level;
	endproperty
	a_clock_low_idle: assert property (p_clock_low_idle) else $error("clock high while idle");

	property p_bit_range;
		@(posedge clk) disable iff (!arst_n)
			phase_q == lcar_pkg::PH_BIT_LO |-> bit_q < 5'(lcar_pkg::DataBits);
	endproperty
	a_bit_range: assert property (p_bit_range) else $error("bit counter overran");

	property p_div_follows;
		@(posedge clk) disable iff (!arst_n) cmd.div_start |=> phase_q == lcar_pkg::PH_DIV;
	endproperty
	a_div_follows: assert property (p_div_follows) else $error("divide not entered");
endmodule
`default_nettype wire

// File: rtl/lcar_datapath.sv
// Datapath: shift register, accumulator, restoring divider, serial scaling
// multiplier, channel offsets and result formation. Depends on lcar_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lcar_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lcar_pkg::dp_cmd_t  cmd,
	input  wire logic               data_level,
	input  wire logic               req_ch,
	input  wire logic               req_tare,
	input  wire logic [7:0]         req_n,
	input  wire logic signed [31:0] inv_scale_a,
	input  wire logic signed [31:0] inv_scale_b,
	output lcar_pkg::dp_sts_t       sts,
	output logic signed [23:0]      raw_average,
	output logic signed [24:0]      net_value,
	output logic signed [31:0]      weight
);
	logic [23:0] word_q;
	logic signed [31:0] sum_q;
	logic signed [31:0] sum_next;
	logic signed [23:0] off_a_q, off_b_q;
	// divider (magnitude, restoring, one bit per cycle)
	logic [31:0] quo_q;
	logic [8:0]  rem_q;
	logic [5:0]  dcnt_q;
	logic        neg_q;
	logic [8:0]  rem_sh;
	// multiplier (shift-add, one bit per cycle)
	logic [5:0]  mcnt_q;
	logic        mbusy_q;
	logic signed [63:0] acc_q;
	logic signed [63:0] mcand_q;
	logic [31:0] mplier_q;
	logic signed [23:0] avg_q;
	logic signed [24:0] net_q;
	logic signed [31:0] scale;
	logic signed [63:0] wide;
	logic signed [47:0] shifted;

	assign rem_sh = {rem_q[7:0], quo_q[31]};
	assign sts.div_done = dcnt_q == 6'd32;
	assign sts.mul_done = mbusy_q && mcnt_q == 6'd32;
	assign scale = req_ch ? inv_scale_b : inv_scale_a;
	// The last conversion is added in the same cycle the divider loads.
	assign sum_next = cmd.accumulate ? sum_q + 32'(signed'(word_q)) : sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_a_q <= '0;
			off_b_q <= '0;
			sum_q   <= '0;
			word_q  <= '0;
			dcnt_q  <= '0;
			mbusy_q <= 1'b0;
			mcnt_q  <= '0;
		end else begin
			if (cmd.start) sum_q <= '0;
			if (cmd.clear_word) word_q <= '0;
			if (cmd.shift_in) word_q <= {word_q[22:0], data_level};
			if (cmd.accumulate) sum_q <= sum_next;
			if (cmd.div_start) begin
				neg_q  <= sum_next[31];
				quo_q  <= sum_next[31] ? 32'(-sum_next) : sum_next;
				rem_q  <= '0;
				dcnt_q <= '0;
			end else if (cmd.div_step && !sts.div_done) begin
				if (rem_sh >= {1'b0, req_n}) begin
					rem_q <= rem_sh - {1'b0, req_n};
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[30:0], 1'b0};
				end
				dcnt_q <= dcnt_q + 6'd1;
			end
			if (cmd.mul_start) begin
				avg_q   <= neg_q ? 24'(-quo_q) : quo_q[23:0];
				net_q   <= (neg_q ? 25'(signed'(24'(-quo_q))) : 25'(signed'(quo_q[23:0])))
					- 25'(req_ch ? off_b_q : off_a_q);
				mcand_q <= 64'(neg_q ? signed'(24'(-quo_q)) : signed'(quo_q[23:0]))
					- 64'(req_ch ? off_b_q : off_a_q);
				mplier_q <= (scale == 32'sd0) ? lcar_pkg::ScaleOne : scale;
				acc_q   <= '0;
				mcnt_q  <= '0;
				mbusy_q <= 1'b1;
				dcnt_q  <= '0;
			end else if (mbusy_q && !sts.mul_done) begin
				// Two's complement multiplier: top bit weighs negative.
				if (mplier_q[0])
					acc_q <= (mcnt_q == 6'd31) ? acc_q - (mcand_q <<< mcnt_q)
						: acc_q + (mcand_q <<< mcnt_q);
				mplier_q <= mplier_q >> 1;
				mcnt_q <= mcnt_q + 6'd1;
			end
			if (cmd.finish) begin
				mbusy_q <= 1'b0;
				if (req_tare) begin
					if (req_ch) off_b_q <= avg_q;
					else off_a_q <= avg_q;
				end
			end
		end
	end

	assign wide = acc_q;
	assign shifted = 48'(wide >>> 16);
	always_comb begin
		raw_average = avg_q;
		net_value = req_tare ? 25'sd0 : net_q;
		if (req_tare) weight = 32'sd0;
		else if (shifted > 48'sh7FFFFFFF) weight = 32'sh7FFFFFFF;
		else if (shifted < -48'sh80000000) weight = 32'sh80000000;
		else weight = shifted[31:0];
	end

	property p_div_bound;
		@(posedge clk) disable iff (!arst_n) dcnt_q <= 6'd32;
	endproperty
	a_div_bound: assert property (p_div_bound) else $error("divider count overran");

	property p_rem_bound;
		@(posedge clk) disable iff (!arst_n) cmd.div_step && dcnt_q != 6'd0 |-> rem_q < {1'b0, req_n};
	endproperty
	a_rem_bound: assert property (p_rem_bound) else $error("remainder out of range");

	property p_mul_bound;
		@(posedge clk) disable iff (!arst_n) mcnt_q <= 6'd32;
	endproperty
	a_mul_bound: assert property (p_mul_bound) else $error("multiplier count overran");
endmodule
`default_nettype wire

// File: rtl/load_cell_adc_reader_core.sv
// Load-cell converter serial reader. Each accepted word is one pin tick and
// yields exactly one result word, registered in the cycle after it is taken.
// The completion tick is held back after the last gain high tick while the
// last sample is added, the 32-step divider runs and then the 32-step
// shift-add multiplier runs.
// Reset (arst_n low) clears state and offsets, sets gain pulses to 1 and both scales to 1.0.
`timescale 1ns / 1ps
`default_nettype none
module load_cell_adc_reader_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic        channel,
	input  wire logic [6:0]  sample_count,
	input  wire logic        data_level,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             clock_level,
	output logic             busy_res,
	output logic             done_res,
	output logic [23:0]      raw_average,
	output logic [24:0]      net_value,
	output logic [31:0]      weight
);
	// Configuration registers.
	logic [1:0] gain_q;
	logic signed [31:0] scale_a_q, scale_b_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= 2'd1;
			scale_a_q <= lcar_pkg::ScaleOne;
			scale_b_q <= lcar_pkg::ScaleOne;
		end else if (cfg_we) begin
			case (cfg_index)
				lcar_pkg::RegGainA:  gain_q <= cfg_data[1:0];
				lcar_pkg::RegScaleA: scale_a_q <= cfg_data;
				lcar_pkg::RegScaleB: scale_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Latched request.
	logic req_ch_q, req_tare_q;
	logic [7:0] req_n_q;
	logic req, tick, out_free, arith_busy;
	lcar_pkg::phase_t phase;
	lcar_pkg::dp_cmd_t cmd;
	lcar_pkg::dp_sts_t sts;
	logic clk_lvl, busy;
	logic signed [23:0] avg;
	logic signed [24:0] net;
	logic signed [31:0] wgt;

	// A word is taken only when the output register is empty or draining,
	// and never while the arithmetic units are working.
	assign out_free = !out_valid || out_ready;
	assign in_ready = out_free && !arith_busy;
	assign tick = in_valid && in_ready;
	assign req = operation == lcar_pkg::OpMeasure || operation == lcar_pkg::OpTare;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch_q <= 1'b0;
			req_tare_q <= 1'b0;
			req_n_q <= 8'd0;
		end else if (cmd.start) begin
			req_ch_q <= channel;
			req_tare_q <= operation == lcar_pkg::OpTare;
			req_n_q <= (sample_count == 7'd0) ? 8'd1 : {1'b0, sample_count};
		end
	end

	lcar_ctrl u_ctrl (
		.clk, .arst_n, .tick, .req, .data_level,
		.req_ch(req_ch_q), .gain_a_pulses(gain_q), .req_n(req_n_q),
		.sts, .phase, .cmd, .clock_level(clk_lvl), .busy, .arith_busy
	);

	lcar_datapath u_dp (
		.clk, .arst_n, .cmd, .data_level,
		.req_ch(req_ch_q), .req_tare(req_tare_q), .req_n(req_n_q),
		.inv_scale_a(scale_a_q), .inv_scale_b(scale_b_q),
		.sts, .raw_average(avg), .net_value(net), .weight(wgt)
	);

	// Output register: one result word per accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			if (tick) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (tick) begin
			clock_level <= clk_lvl;
			busy_res <= busy;
			done_res <= cmd.finish;
			raw_average <= cmd.finish ? avg : 24'd0;
			net_value <= cmd.finish ? net : 25'd0;
			weight <= cmd.finish ? wgt : 32'd0;
		end
	end

	property p_done_busy;
		@(posedge clk) disable iff (!arst_n) out_valid && done_res |-> busy_res;
	endproperty
	a_done_busy: assert property (p_done_busy) else $error("done without busy");

	property p_hold;
		@(posedge clk) disable iff (!arst_n) out_valid && !out_ready |=> out_valid;
	endproperty
	a_hold: assert property (p_hold) else $error("result word dropped");

	property p_no_take_busy_units;
		@(posedge clk) disable iff (!arst_n) phase == lcar_pkg::PH_DIV |-> !in_ready;
	endproperty
	a_no_take: assert property (p_no_take_busy_units) else $error("word taken mid-divide");
endmodule
`default_nettype wire

// File: bench/load_cell_adc_reader_core_tb.sv
// Self-checking bench for the load-cell converter reader core.
// Depends on lcar_pkg, lcar_stream_if and load_cell_adc_reader_core from the RTL.
`timescale 1ns / 1ps
module load_cell_adc_reader_core_tb;

	// One pin tick going into the block.
	typedef struct packed {
		logic [1:0] operation;
		logic       channel;
		logic [6:0] sample_count;
		logic       data_level;
	} tick_t;

	// One result word coming back for each tick.
	typedef struct packed {
		logic        clock_level;
		logic        busy_res;
		logic        done_res;
		logic [23:0] raw_average;
		logic [24:0] net_value;
		logic [31:0] weight;
	} pin_result_t;

	localparam int CycleLimit = 2000000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	lcar_stream_if #(.T(tick_t))       in_ch ();
	lcar_stream_if #(.T(pin_result_t)) out_ch ();

	load_cell_adc_reader_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_ch.valid),
		.in_ready    (in_ch.ready),
		.operation   (in_ch.data.operation),
		.channel     (in_ch.data.channel),
		.sample_count(in_ch.data.sample_count),
		.data_level  (in_ch.data.data_level),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready),
		.clock_level (out_ch.data.clock_level),
		.busy_res    (out_ch.data.busy_res),
		.done_res    (out_ch.data.done_res),
		.raw_average (out_ch.data.raw_average),
		.net_value   (out_ch.data.net_value),
		.weight      (out_ch.data.weight)
	);

	// Words waiting for the driver, and the results they must produce.
	tick_t       pending_ticks[$];
	pin_result_t expected_results[$];

	// Idle percentages for sender and receiver; changed between phases.
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int          error_count;
	int          cycle_count;

	// Shadow copy of the block: configuration and conversion state.
	logic [1:0]   gain_pulses_q;
	logic [31:0]  scale_a_q;
	logic [31:0]  scale_b_q;
	lcar_pkg::phase_t pin_phase;
	int           bit_index;
	int           pulse_index;
	int           conversions;
	logic [23:0]  shift_word;
	longint       running_sum;
	longint       offset_a;
	longint       offset_b;
	logic [1:0]   req_op;
	logic         req_ch;
	int           req_n;

	// Word that the simulated converter shifts out on the current conversion.
	logic [23:0]  adc_word;
	int           done_count;

	initial begin
		clk = 1'b0;
	end

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		error_count++;
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
	endtask

	// Computes the result of one tick and advances the shadow state.
	task automatic predict_tick(input tick_t t, output pin_result_t r);
		int                 cnt;
		int                 pulses;
		longint             avg;
		longint             net;
		longint             wgt;
		longint             s;
		logic signed [23:0] word_s;
		logic signed [23:0] avg24;
		logic signed [31:0] scale_s;
		r = '0;
		r.busy_res = 1'b1;
		cnt = t.sample_count;
		case (pin_phase)
			lcar_pkg::PH_IDLE: begin
				if (t.operation == lcar_pkg::OpMeasure || t.operation == lcar_pkg::OpTare) begin
					if (cnt == 0)
						cnt = 1;
					req_op = t.operation;
					req_ch = t.channel;
					req_n = cnt;
					conversions = 0;
					running_sum = 0;
					pin_phase = lcar_pkg::PH_WAIT;
				end else begin
					// Operation three and no request both leave the block idle.
					r.busy_res = 1'b0;
				end
			end
			lcar_pkg::PH_WAIT: begin
				if (!t.data_level) begin
					bit_index = 0;
					shift_word = '0;
					pin_phase = lcar_pkg::PH_BIT_HI;
				end
			end
			lcar_pkg::PH_BIT_HI: begin
				r.clock_level = 1'b1;
				pin_phase = lcar_pkg::PH_BIT_LO;
			end
			lcar_pkg::PH_BIT_LO: begin
				shift_word = {shift_word[22:0], t.data_level};
				bit_index++;
				if (bit_index >= lcar_pkg::DataBits) begin
					pulse_index = 0;
					pin_phase = lcar_pkg::PH_GAIN_HI;
				end else begin
					pin_phase = lcar_pkg::PH_BIT_HI;
				end
			end
			lcar_pkg::PH_GAIN_HI: begin
				r.clock_level = 1'b1;
				pin_phase = lcar_pkg::PH_GAIN_LO;
			end
			default: begin
				// Channel B always gets two pulses; a zero gain setting acts as one.
				pulses = req_ch ? 2 : (gain_pulses_q == 2'd0 ? 1 : int'(gain_pulses_q));
				pulse_index++;
				if (pulse_index < pulses) begin
					pin_phase = lcar_pkg::PH_GAIN_HI;
				end else begin
					word_s = shift_word;
					// The first conversion after a request is thrown away.
					if (conversions > 0)
						running_sum += longint'(word_s);
					conversions++;
					if (conversions <= req_n) begin
						pin_phase = lcar_pkg::PH_WAIT;
					end else begin
						avg = running_sum / req_n;
						avg24 = avg[23:0];
						avg = longint'(avg24);
						r.done_res = 1'b1;
						r.raw_average = avg24;
						pin_phase = lcar_pkg::PH_IDLE;
						if (req_op == lcar_pkg::OpTare) begin
							if (req_ch)
								offset_b = avg;
							else
								offset_a = avg;
						end else begin
							scale_s = req_ch ? scale_b_q : scale_a_q;
							s = longint'(scale_s);
							if (s == 0)
								s = 65536;
							net = avg - (req_ch ? offset_b : offset_a);
							wgt = (net * s) >>> 16;
							if (wgt > 64'sd2147483647)
								wgt = 64'sd2147483647;
							if (wgt < -64'sd2147483648)
								wgt = -64'sd2147483648;
							r.net_value = net[24:0];
							r.weight = wgt[31:0];
						end
					end
				end
			end
		endcase
	endtask

	task automatic queue_tick(input logic [1:0] op, input logic ch, input logic [6:0] cnt,
		input logic din);
		tick_t       t;
		pin_result_t r;
		t.operation = op;
		t.channel = ch;
		t.sample_count = cnt;
		t.data_level = din;
		predict_tick(t, r);
		if (r.done_res)
			done_count++;
		pending_ticks.push_back(t);
		expected_results.push_back(r);
	endtask

	// Issues one request and plays the converter until the request completes.
	// Pattern 0 gives random words, 1 the largest, 2 the smallest, 3 zero.
	task automatic run_request(input logic [1:0] op, input logic ch, input logic [6:0] cnt,
		input int pattern, input bit noisy);
		logic din;
		logic [1:0] nop;
		queue_tick(op, ch, cnt, 1'($urandom_range(0, 1)));
		while (pin_phase != lcar_pkg::PH_IDLE) begin
			din = 1'($urandom_range(0, 1));
			if (pin_phase == lcar_pkg::PH_WAIT) begin
				case (pattern)
					1: adc_word = 24'h7fffff;
					2: adc_word = 24'h800000;
					3: adc_word = 24'h000000;
					default: adc_word = 24'($urandom);
				endcase
				// Keep the data pin high for a while before the conversion is ready.
				din = ($urandom_range(0, 2) != 0);
			end else if (pin_phase == lcar_pkg::PH_BIT_LO) begin
				din = adc_word[lcar_pkg::DataBits - 1 - bit_index];
			end
			// Requests that arrive while busy must be ignored.
			if (noisy && $urandom_range(0, 9) == 0) begin
				nop = 2'($urandom_range(0, 3));
				queue_tick(nop, 1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)), din);
			end else begin
				queue_tick(lcar_pkg::OpNone, 1'($urandom_range(0, 1)),
					7'($urandom_range(0, 127)), din);
			end
		end
	endtask

	task automatic run_directed();
		run_request(lcar_pkg::OpTare, 1'b0, 7'd0, 3, 1'b0);
		run_request(lcar_pkg::OpMeasure, 1'b0, 7'd1, 0, 1'b0);
		run_request(lcar_pkg::OpMeasure, 1'b1, 7'd3, 0, 1'b1);
		run_request(lcar_pkg::OpTare, 1'b0, 7'd2, 1, 1'b0);
		run_request(lcar_pkg::OpMeasure, 1'b0, 7'd1, 2, 1'b0);
		run_request(lcar_pkg::OpTare, 1'b1, 7'd1, 2, 1'b0);
		run_request(lcar_pkg::OpMeasure, 1'b1, 7'd2, 1, 1'b0);
		run_request(lcar_pkg::OpMeasure, 1'b1, 7'd1, 3, 1'b1);
		// Operation three and a plain idle tick must not start anything.
		queue_tick(2'd3, 1'b1, 7'd127, 1'b0);
		queue_tick(lcar_pkg::OpNone, 1'b0, 7'd0, 1'b1);
		run_request(lcar_pkg::OpTare, 1'b0, 7'd1, 3, 1'b0);
		run_request(lcar_pkg::OpTare, 1'b1, 7'd1, 3, 1'b0);
	endtask

	task automatic run_random(input int min_ticks, input int min_done);
		int start_ticks;
		int start_done;
		int pattern;
		int cnt;
		start_done = done_count;
		start_ticks = 0;
		while (start_ticks < min_ticks || done_count - start_done < min_done) begin
			// A few idle or malformed ticks between requests.
			repeat ($urandom_range(0, 3)) begin
				queue_tick($urandom_range(0, 1) ? lcar_pkg::OpNone : 2'd3,
					1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
					1'($urandom_range(0, 1)));
				start_ticks++;
			end
			pattern = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
			cnt = ($urandom_range(0, 49) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
			start_ticks -= expected_results.size();
			run_request(2'($urandom_range(1, 2)), 1'($urandom_range(0, 1)), 7'(cnt),
				pattern, 1'b1);
			start_ticks += expected_results.size();
		end
	endtask

	task automatic write_register(input logic [1:0] index, input logic [31:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (index)
			lcar_pkg::RegGainA:  gain_pulses_q = value[1:0];
			lcar_pkg::RegScaleA: scale_a_q = value;
			lcar_pkg::RegScaleB: scale_b_q = value;
			default: ;
		endcase
	endtask

	// The block is idle once every queued word has come back.
	task automatic drain();
		while (pending_ticks.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Sender: presents the next word, holding it until the handshake completes.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				in_ch.valid <= 1'b1;
				in_ch.data <= pending_ticks.pop_front();
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: stalls at random in the idling phases.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ch.ready <= 1'b0;
		else
			out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Monitor: each result word is checked against the oldest expectation.
	always @(posedge clk) begin
		pin_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected word", out_ch.data.weight, 0);
			end else begin
				want = expected_results.pop_front();
				if (out_ch.data.clock_level !== want.clock_level)
					report_mismatch("clock_level", out_ch.data.clock_level, want.clock_level);
				if (out_ch.data.busy_res !== want.busy_res)
					report_mismatch("busy_res", out_ch.data.busy_res, want.busy_res);
				if (out_ch.data.done_res !== want.done_res)
					report_mismatch("done_res", out_ch.data.done_res, want.done_res);
				if (out_ch.data.raw_average !== want.raw_average)
					report_mismatch("raw_average", out_ch.data.raw_average, want.raw_average);
				if (out_ch.data.net_value !== want.net_value)
					report_mismatch("net_value", out_ch.data.net_value, want.net_value);
				if (out_ch.data.weight !== want.weight)
					report_mismatch("weight", out_ch.data.weight, want.weight);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = lcar_pkg::RegGainA;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		error_count = 0;
		cycle_count = 0;
		done_count = 0;
		send_idle_pct = 37;
		recv_idle_pct = 51;
		// Shadow state starts as the block does after reset.
		gain_pulses_q = 2'd1;
		scale_a_q = lcar_pkg::ScaleOne;
		scale_b_q = lcar_pkg::ScaleOne;
		pin_phase = lcar_pkg::PH_IDLE;
		bit_index = 0;
		pulse_index = 0;
		conversions = 0;
		shift_word = '0;
		running_sum = 0;
		offset_a = 0;
		offset_b = 0;
		req_op = lcar_pkg::OpNone;
		req_ch = 1'b0;
		req_n = 0;
		adc_word = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings first, with the directed requests.
		run_directed();
		drain();

		// Maximum gain pulses, scale A of zero meaning one, negative scale B.
		write_register(lcar_pkg::RegGainA, 32'd3);
		write_register(lcar_pkg::RegScaleA, 32'd0);
		write_register(lcar_pkg::RegScaleB, -32'sd65536);
		run_random(100, 1);
		drain();

		// Swap the idling roles; extreme scales to force saturation.
		send_idle_pct = 51;
		recv_idle_pct = 37;
		write_register(lcar_pkg::RegGainA, 32'd0);
		write_register(lcar_pkg::RegScaleA, 32'h7fffffff);
		write_register(lcar_pkg::RegScaleB, 32'h80000000);
		run_random(100, 1);
		drain();

		write_register(lcar_pkg::RegGainA, 32'd2);
		write_register(lcar_pkg::RegScaleA, $urandom);
		write_register(lcar_pkg::RegScaleB, 32'd1);
		run_random(100, 1);
		drain();

		// No idling on either side for the last stretch.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_register(lcar_pkg::RegGainA, 32'd1);
		write_register(lcar_pkg::RegScaleA, 32'd98304);
		write_register(lcar_pkg::RegScaleB, 32'd0);
		run_random(100, 1);
		drain();

		repeat (100) @(posedge clk);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: sim.f
rtl/lcar_pkg.sv
rtl/lcar_stream_if.sv
rtl/lcar_ctrl.sv
rtl/lcar_datapath.sv
rtl/load_cell_adc_reader_core.sv
bench/load_cell_adc_reader_core_tb.sv
